@@ rtl/tifc_pkg.sv @@
// Package for the turn-indicator flasher control unit.
// Holds light, mode, lever and register codes, reset values and shared types.
// No dependencies.
package tifc_pkg;

  // Default width of the tick counter
  localparam int TimeWidth = 32;

  // Field widths
  localparam int VoltWidth  = 8;
  localparam int CfgWidth   = 8;
  localparam int CodeWidth  = 2;
  localparam int IndexWidth = 2;

  // Light codes
  localparam logic [CodeWidth-1:0] LIGHT_BOTH  = 2'd0;
  localparam logic [CodeWidth-1:0] LIGHT_LEFT  = 2'd1;
  localparam logic [CodeWidth-1:0] LIGHT_OFF   = 2'd2;
  localparam logic [CodeWidth-1:0] LIGHT_RIGHT = 2'd3;

  // Mode codes
  localparam logic [CodeWidth-1:0] MODE_HAZARD = 2'd0;
  localparam logic [CodeWidth-1:0] MODE_LEFT   = 2'd1;
  localparam logic [CodeWidth-1:0] MODE_NONE   = 2'd2;
  localparam logic [CodeWidth-1:0] MODE_RIGHT  = 2'd3;

  // Lever codes (the fourth code matches none of them)
  localparam logic [CodeWidth-1:0] LEVER_NEUTRAL = 2'd0;
  localparam logic [CodeWidth-1:0] LEVER_LEFT    = 2'd1;
  localparam logic [CodeWidth-1:0] LEVER_RIGHT   = 2'd2;

  // Configuration register indexes
  localparam logic [IndexWidth-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IndexWidth-1:0] REG_ON_DUR    = 2'd1;
  localparam logic [IndexWidth-1:0] REG_OFF_DUR   = 2'd2;

  // Register reset values
  localparam logic [CfgWidth-1:0] THRESHOLD_RST = 8'd80;
  localparam logic [CfgWidth-1:0] ON_DUR_RST    = 8'd17;
  localparam logic [CfgWidth-1:0] OFF_DUR_RST   = 8'd11;

  // Controller state seen by the rule logic (phase start kept apart, its width is a parameter)
  typedef struct packed {
    logic [CodeWidth-1:0] light;
    logic [CodeWidth-1:0] mode;
    logic [VoltWidth-1:0] prev_voltage;
    logic [CodeWidth-1:0] prev_lever;
    logic                 prev_hazard;
    logic [CodeWidth-1:0] prev_mode;
  } ctrl_state_t;

  // Configuration registers
  typedef struct packed {
    logic [CfgWidth-1:0] threshold;
    logic [CfgWidth-1:0] on_dur;
    logic [CfgWidth-1:0] off_dur;
  } cfg_regs_t;

  // Rule outcome
  typedef struct packed {
    logic                 fired;
    logic                 set_light;
    logic                 set_mode;
    logic [CodeWidth-1:0] light;
    logic [CodeWidth-1:0] mode;
  } rule_result_t;

endpackage

@@ rtl/tifc_rules.sv @@
// Priority rule evaluation for the flasher control unit.
// Pure combinational: picks the first matching rule and its new light or mode.
// Depends on tifc_pkg.
module tifc_rules import tifc_pkg::*; #(
  parameter int TIME_WIDTH = TimeWidth
) (
  input  cfg_regs_t              cfg,
  input  ctrl_state_t            st,
  input  logic [TIME_WIDTH-1:0]  phase_start,
  input  logic [VoltWidth-1:0]   voltage,
  input  logic [CodeWidth-1:0]   lever,
  input  logic                   hazard_switch,
  input  logic [TIME_WIDTH-1:0]  now,
  output rule_result_t           res
);

  logic                  ok;
  logic                  was_ok;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  on_done;
  logic                  off_done;

  // Voltage checks and phase timing (elapsed wraps with the counter)
  assign ok       = voltage > cfg.threshold;
  assign was_ok   = st.prev_voltage > cfg.threshold;
  assign elapsed  = now - phase_start;
  assign on_done  = elapsed >= TIME_WIDTH'(cfg.on_dur);
  assign off_done = elapsed >= TIME_WIDTH'(cfg.off_dur);

  // First matching rule wins; light rules come before mode rules
  always_comb begin
    res = '{fired: 1'b1, set_light: 1'b1, set_mode: 1'b0,
            light: st.light, mode: st.mode};
    priority if (was_ok && !ok && st.light != LIGHT_OFF) begin
      // undervoltage edge
      res.light = LIGHT_OFF;
    end else if (st.mode == MODE_LEFT && ok && (st.prev_mode != MODE_LEFT || !was_ok)
                 && st.light != LIGHT_LEFT) begin
      res.light = LIGHT_LEFT;
    end else if (st.mode == MODE_RIGHT && ok && (st.prev_mode != MODE_RIGHT || !was_ok)
                 && st.light != LIGHT_RIGHT) begin
      res.light = LIGHT_RIGHT;
    end else if (st.mode == MODE_HAZARD && ok && (st.prev_mode != MODE_HAZARD || !was_ok)
                 && st.light != LIGHT_BOTH) begin
      res.light = LIGHT_BOTH;
    end else if (st.mode == MODE_NONE && ok && st.light != LIGHT_OFF) begin
      res.light = LIGHT_OFF;
    end else if ((st.light == LIGHT_RIGHT || st.light == LIGHT_LEFT) && ok && on_done) begin
      // on phase over
      res.light = LIGHT_OFF;
    end else if (st.mode == MODE_LEFT && st.light == LIGHT_OFF && ok && off_done) begin
      res.light = LIGHT_LEFT;
    end else if (st.mode == MODE_RIGHT && st.light == LIGHT_OFF && ok && off_done) begin
      res.light = LIGHT_RIGHT;
    end else if (st.mode == MODE_HAZARD && st.light == LIGHT_OFF && ok && off_done) begin
      res.light = LIGHT_BOTH;
    end else begin
      // mode rules from lever and hazard edges
      res.set_light = 1'b0;
      res.set_mode  = 1'b1;
      priority if (!hazard_switch && st.prev_lever != LEVER_LEFT && lever == LEVER_LEFT
                   && st.mode != MODE_LEFT) begin
        res.mode = MODE_LEFT;
      end else if (!hazard_switch && st.prev_lever != LEVER_RIGHT && lever == LEVER_RIGHT
                   && st.mode != MODE_RIGHT) begin
        res.mode = MODE_RIGHT;
      end else if (!st.prev_hazard && hazard_switch && st.mode != MODE_HAZARD) begin
        res.mode = MODE_HAZARD;
      end else if (st.prev_lever != LEVER_LEFT && lever == LEVER_LEFT && st.prev_hazard
                   && hazard_switch && st.mode != MODE_LEFT) begin
        res.mode = MODE_LEFT;
      end else if (st.prev_lever != LEVER_RIGHT && lever == LEVER_RIGHT && st.prev_hazard
                   && hazard_switch && st.mode != MODE_RIGHT) begin
        res.mode = MODE_RIGHT;
      end else if (st.mode != MODE_HAZARD && st.prev_lever != LEVER_NEUTRAL
                   && lever == LEVER_NEUTRAL && st.prev_hazard && hazard_switch) begin
        res.mode = MODE_HAZARD;
      end else if (st.mode != MODE_LEFT && st.prev_lever == LEVER_LEFT && lever == LEVER_LEFT
                   && st.prev_hazard && !hazard_switch) begin
        res.mode = MODE_LEFT;
      end else if (st.mode != MODE_RIGHT && st.prev_lever == LEVER_RIGHT
                   && lever == LEVER_RIGHT && st.prev_hazard && !hazard_switch) begin
        res.mode = MODE_RIGHT;
      end else begin
        // no rule
        res.fired    = 1'b0;
        res.set_mode = 1'b0;
      end
    end
  end

endmodule

@@ rtl/turn_indicator_flasher_control_unit.sv @@
// Top level of the turn-indicator flasher control unit.
// Input register, rule evaluation (tifc_rules), controller state and result register.
// Depends on tifc_pkg and tifc_rules.

// Takes one control sample (voltage, lever, hazard switch, tick count) per transaction
// and returns one result (lights, mode, changed) per sample, in order. Throughput is
// one sample per clock unless out_ready stalls the result channel; a sample's result
// passes the input register, then the result register, and the controller state is
// updated when the sample leaves the input register. Configuration registers are
// written through a plain write port and must only be written while no sample is in
// flight. The tick counter width is TIME_WIDTH; elapsed time wraps modulo 2^TIME_WIDTH.
module turn_indicator_flasher_control_unit import tifc_pkg::*; #(
  parameter int TIME_WIDTH = TimeWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]   cfg_data,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VoltWidth-1:0]  voltage,
  input  logic [CodeWidth-1:0]  lever,
  input  logic                  hazard_switch,
  input  logic [TIME_WIDTH-1:0] now,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CodeWidth-1:0]  lights,
  output logic [CodeWidth-1:0]  mode,
  output logic                  changed
);

  cfg_regs_t             cfg;
  ctrl_state_t           st;
  logic [TIME_WIDTH-1:0] phase_start;

  logic                  s1_valid;
  logic [VoltWidth-1:0]  s1_voltage;
  logic [CodeWidth-1:0]  s1_lever;
  logic                  s1_hazard;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  s1_advance;

  rule_result_t          res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{threshold: THRESHOLD_RST, on_dur: ON_DUR_RST, off_dur: OFF_DUR_RST};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data;
        REG_ON_DUR:    cfg.on_dur    <= cfg_data;
        REG_OFF_DUR:   cfg.off_dur   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_voltage <= voltage;
      s1_lever   <= lever;
      s1_hazard  <= hazard_switch;
      s1_now     <= now;
    end
  end

  // Rule evaluation
  tifc_rules #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_rules (
    .cfg           (cfg),
    .st            (st),
    .phase_start   (phase_start),
    .voltage       (s1_voltage),
    .lever         (s1_lever),
    .hazard_switch (s1_hazard),
    .now           (s1_now),
    .res           (res)
  );

  // Controller state update, one sample per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{light: LIGHT_OFF, mode: MODE_NONE, prev_voltage: '0,
                       prev_lever: LEVER_NEUTRAL, prev_hazard: 1'b0, prev_mode: MODE_NONE};
      phase_start <= '0;
    end else if (s1_advance) begin
      if (res.set_light) st.light <= res.light;
      if (res.set_mode)  st.mode  <= res.mode;
      if (res.fired)     phase_start <= s1_now;
      st.prev_voltage <= s1_voltage;
      st.prev_lever   <= s1_lever;
      st.prev_hazard  <= s1_hazard;
      // mode held at the start of this sample, seen as an edge next time
      st.prev_mode    <= st.mode;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      lights  <= res.light;
      mode    <= res.mode;
      changed <= res.fired;
    end
  end

endmodule

@@ tb/turn_indicator_flasher_control_unit_tb.sv @@
// Testbench for turn_indicator_flasher_control_unit: directed and random control samples,
// checked one result at a time against an in-bench model of the flasher rules.
// Depends on tifc_pkg and the flasher RTL.
module turn_indicator_flasher_control_unit_tb;
  import tifc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Lever code that is neither neutral, left nor right
  localparam logic [CodeWidth-1:0] LEVER_INVALID = 2'd3;

  typedef struct packed {
    logic [CodeWidth-1:0] lights;
    logic [CodeWidth-1:0] mode;
    logic                 changed;
  } indication_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IndexWidth-1:0] cfg_index = REG_THRESHOLD;
  logic [CfgWidth-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VoltWidth-1:0]  voltage = '0;
  logic [CodeWidth-1:0]  lever = LEVER_NEUTRAL;
  logic                  hazard_switch = 1'b0;
  logic [TimeWidth-1:0]  now = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CodeWidth-1:0]  lights;
  logic [CodeWidth-1:0]  mode;
  logic                  changed;

  turn_indicator_flasher_control_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .voltage(voltage), .lever(lever), .hazard_switch(hazard_switch), .now(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .lights(lights), .mode(mode), .changed(changed)
  );

  always #10 clk = ~clk;

  // Shadow copy of the controller: registers and state
  logic [CfgWidth-1:0]  sh_threshold = THRESHOLD_RST;
  logic [CfgWidth-1:0]  sh_on_dur = ON_DUR_RST;
  logic [CfgWidth-1:0]  sh_off_dur = OFF_DUR_RST;
  logic [CodeWidth-1:0] sh_light = LIGHT_OFF;
  logic [CodeWidth-1:0] sh_mode = MODE_NONE;
  logic [TimeWidth-1:0] sh_phase_start = '0;
  logic [VoltWidth-1:0] sh_prev_volt = '0;
  logic [CodeWidth-1:0] sh_prev_lever = LEVER_NEUTRAL;
  logic                 sh_prev_hazard = 1'b0;
  logic [CodeWidth-1:0] sh_prev_mode = MODE_NONE;

  indication_t pending_indications[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // Driving scenario for the random part
  logic [CodeWidth-1:0] drive_lever = LEVER_NEUTRAL;
  logic                 drive_hazard = 1'b0;
  logic [TimeWidth-1:0] drive_now = '0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // First matching rule wins: light rules, then mode rules
  task automatic predict_flasher(input logic [VoltWidth-1:0] v, input logic [CodeWidth-1:0] lev,
                                 input logic hz, input logic [TimeWidth-1:0] t);
    logic ok, was_ok, fired;
    logic [CodeWidth-1:0] nl, nm;
    logic [TimeWidth-1:0] elapsed;
    ok = v > sh_threshold;
    was_ok = sh_prev_volt > sh_threshold;
    elapsed = t - sh_phase_start;
    nl = sh_light;
    nm = sh_mode;
    fired = 1'b1;
    if (was_ok && !ok && sh_light != LIGHT_OFF)
      nl = LIGHT_OFF;
    else if (sh_mode == MODE_LEFT && ok && (sh_prev_mode != MODE_LEFT || !was_ok)
             && sh_light != LIGHT_LEFT)
      nl = LIGHT_LEFT;
    else if (sh_mode == MODE_RIGHT && ok && (sh_prev_mode != MODE_RIGHT || !was_ok)
             && sh_light != LIGHT_RIGHT)
      nl = LIGHT_RIGHT;
    else if (sh_mode == MODE_HAZARD && ok && (sh_prev_mode != MODE_HAZARD || !was_ok)
             && sh_light != LIGHT_BOTH)
      nl = LIGHT_BOTH;
    else if (sh_mode == MODE_NONE && ok && sh_light != LIGHT_OFF)
      nl = LIGHT_OFF;
    else if ((sh_light == LIGHT_RIGHT || sh_light == LIGHT_LEFT) && ok && elapsed >= sh_on_dur)
      nl = LIGHT_OFF;
    else if (sh_mode == MODE_LEFT && sh_light == LIGHT_OFF && ok && elapsed >= sh_off_dur)
      nl = LIGHT_LEFT;
    else if (sh_mode == MODE_RIGHT && sh_light == LIGHT_OFF && ok && elapsed >= sh_off_dur)
      nl = LIGHT_RIGHT;
    else if (sh_mode == MODE_HAZARD && sh_light == LIGHT_OFF && ok && elapsed >= sh_off_dur)
      nl = LIGHT_BOTH;
    else if (!hz && sh_prev_lever != LEVER_LEFT && lev == LEVER_LEFT && sh_mode != MODE_LEFT)
      nm = MODE_LEFT;
    else if (!hz && sh_prev_lever != LEVER_RIGHT && lev == LEVER_RIGHT && sh_mode != MODE_RIGHT)
      nm = MODE_RIGHT;
    else if (!sh_prev_hazard && hz && sh_mode != MODE_HAZARD)
      nm = MODE_HAZARD;
    else if (sh_prev_lever != LEVER_LEFT && lev == LEVER_LEFT && sh_prev_hazard && hz
             && sh_mode != MODE_LEFT)
      nm = MODE_LEFT;
    else if (sh_prev_lever != LEVER_RIGHT && lev == LEVER_RIGHT && sh_prev_hazard && hz
             && sh_mode != MODE_RIGHT)
      nm = MODE_RIGHT;
    else if (sh_mode != MODE_HAZARD && sh_prev_lever != LEVER_NEUTRAL && lev == LEVER_NEUTRAL
             && sh_prev_hazard && hz)
      nm = MODE_HAZARD;
    else if (sh_mode != MODE_LEFT && sh_prev_lever == LEVER_LEFT && lev == LEVER_LEFT
             && sh_prev_hazard && !hz)
      nm = MODE_LEFT;
    else if (sh_mode != MODE_RIGHT && sh_prev_lever == LEVER_RIGHT && lev == LEVER_RIGHT
             && sh_prev_hazard && !hz)
      nm = MODE_RIGHT;
    else
      fired = 1'b0;
    // Any fired rule restarts the phase timer; prev_mode lags by one step
    if (fired) sh_phase_start = t;
    sh_prev_mode = sh_mode;
    sh_light = nl;
    sh_mode = nm;
    sh_prev_volt = v;
    sh_prev_lever = lev;
    sh_prev_hazard = hz;
    pending_indications.push_back('{lights: nl, mode: nm, changed: fired});
  endtask

  // One sample transaction; valid stays high afterwards unless the next call idles
  task automatic send_sample(input logic [VoltWidth-1:0] v, input logic [CodeWidth-1:0] lev,
                             input logic hz, input logic [TimeWidth-1:0] t);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    voltage <= v;
    lever <= lev;
    hazard_switch <= hz;
    now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_flasher(v, lev, hz, t);
  endtask

  // Drop valid in the step of the last transaction, then wait for every result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_indications.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle
  task automatic write_regs(input logic [CfgWidth-1:0] th, input logic [CfgWidth-1:0] on_d,
                            input logic [CfgWidth-1:0] off_d);
    cfg_write <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= th;
    @(posedge clk);
    cfg_index <= REG_ON_DUR;
    cfg_data <= on_d;
    @(posedge clk);
    cfg_index <= REG_OFF_DUR;
    cfg_data <= off_d;
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_threshold = th;
    sh_on_dur = on_d;
    sh_off_dur = off_d;
  endtask

  // Plausible driving: lever held for stretches, voltage mostly healthy, time creeping on
  task automatic send_drive_sample();
    logic [31:0] noise;
    logic [VoltWidth-1:0] v;
    int span;
    int pick;
    if ($urandom_range(99) < 6) begin
      noise = $urandom;
      send_sample(noise[7:0], noise[9:8], noise[10], $urandom);
    end else begin
      if ($urandom_range(99) < 10)
        drive_lever = ($urandom_range(9) == 0) ? LEVER_INVALID : 2'($urandom_range(0, 2));
      if ($urandom_range(99) < 6) drive_hazard = ~drive_hazard;
      if ($urandom_range(99) < 85 && sh_threshold != 8'hFF)
        v = 8'($urandom_range(int'(sh_threshold) + 1, 255));
      else
        v = 8'($urandom_range(0, int'(sh_threshold)));
      span = ((sh_on_dur > sh_off_dur) ? int'(sh_on_dur) : int'(sh_off_dur)) / 3 + 3;
      pick = $urandom_range(99);
      if (pick <= 2)
        drive_now = $urandom;
      else if (pick <= 7)
        drive_now += $urandom_range(256, 1 << 20);
      else
        drive_now += $urandom_range(0, span);
      send_sample(v, drive_lever, drive_hazard, drive_now);
    end
  endtask

  // Result side: check each transaction, stall at random or for a requested stretch
  always @(posedge clk) begin
    indication_t exp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_indications.size() == 0) begin
          flag_mismatch($sformatf("unexpected result lights %0d mode %0d changed %0d",
                                  lights, mode, changed));
        end else begin
          exp = pending_indications.pop_front();
          if (lights !== exp.lights)
            flag_mismatch($sformatf("lights %0d, expected %0d", lights, exp.lights));
          if (mode !== exp.mode)
            flag_mismatch($sformatf("mode %0d, expected %0d", mode, exp.mode));
          if (changed !== exp.changed)
            flag_mismatch($sformatf("changed %0d, expected %0d", changed, exp.changed));
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Walk through the rules under the reset settings
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(8'd0,   LEVER_NEUTRAL, 1'b0, 32'd0);           // quiet, all low
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd1);           // lever left selects mode
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd2);           // left light comes on
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd18);          // one tick short of on time
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd19);          // on time reached
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd29);          // one short of off time
    send_sample(8'd255, LEVER_LEFT,    1'b0, 32'd30);          // off time reached
    send_sample(8'd80,  LEVER_LEFT,    1'b0, 32'd31);          // voltage at threshold: drop
    send_sample(8'd81,  LEVER_LEFT,    1'b0, 32'd32);          // recovery relights
    send_sample(8'd81,  LEVER_INVALID, 1'b1, 32'd33);          // hazard on, odd lever code
    send_sample(8'd200, LEVER_INVALID, 1'b1, 32'd34);          // both lights
    send_sample(8'd200, LEVER_RIGHT,   1'b1, 32'd35);          // lever under hazard
    send_sample(8'd200, LEVER_RIGHT,   1'b1, 32'd36);
    send_sample(8'd200, LEVER_NEUTRAL, 1'b1, 32'd37);          // back to neutral under hazard
    send_sample(8'd200, LEVER_LEFT,    1'b1, 32'd38);
    send_sample(8'd200, LEVER_NEUTRAL, 1'b1, 32'd39);
    send_sample(8'd200, LEVER_LEFT,    1'b1, 32'd40);
    send_sample(8'd200, LEVER_LEFT,    1'b0, 32'd41);
    send_sample(8'd200, LEVER_LEFT,    1'b1, 32'd42);          // hazard while left
    send_sample(8'd200, LEVER_LEFT,    1'b1, 32'd43);
    send_sample(8'd200, LEVER_LEFT,    1'b0, 32'd44);          // hazard off, lever held left
    send_sample(8'd200, LEVER_RIGHT,   1'b1, 32'd45);
    send_sample(8'd200, LEVER_RIGHT,   1'b0, 32'd46);          // hazard off, lever held right
    send_sample(8'd255, LEVER_RIGHT,   1'b0, 32'hFFFF_FFF8);   // phase starts near wrap
    send_sample(8'd255, LEVER_RIGHT,   1'b0, 32'h0000_0009);   // elapsed across the wrap
    send_sample(8'd0,   LEVER_NEUTRAL, 1'b0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_drive_sample();
    drain_results();
  endtask

  // Register extremes and one random setting
  task automatic test_register_settings();
    write_regs(8'd0, 8'd0, 8'd0);
    test_traffic(20, 20, 40);
    write_regs(8'd255, 8'd255, 8'd255);
    test_traffic(20, 20, 40);
    write_regs(8'($urandom_range(40, 200)), 8'($urandom_range(1, 40)),
               8'($urandom_range(1, 40)));
    test_traffic(20, 20, 40);
    write_regs(THRESHOLD_RST, ON_DUR_RST, OFF_DUR_RST);
  endtask

  // Output stalled for a long stretch while input keeps offering samples
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 40;
    repeat (30) send_drive_sample();
    drain_results();
  endtask

  // Input goes quiet until every result is back, then resumes
  task automatic test_sender_pause();
    test_traffic(0, 30, 15);
    test_traffic(0, 30, 15);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_traffic(14, 50, 150);
    test_traffic(50, 14, 150);
    test_traffic(0, 0, 150);
    test_register_settings();
    test_backpressure();
    test_sender_pause();
    repeat (10) @(posedge clk);
    while (pending_indications.size() != 0) begin
      flag_mismatch("expected result never arrived");
      void'(pending_indications.pop_front());
    end
    if (mismatch_count == 0)
      $display("turn_indicator_flasher_control_unit_tb: clean");
    else
      $display("turn_indicator_flasher_control_unit_tb: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("turn_indicator_flasher_control_unit_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tifc_pkg.sv
rtl/tifc_rules.sv
rtl/turn_indicator_flasher_control_unit.sv
tb/turn_indicator_flasher_control_unit_tb.sv
